// ===== rtl/core/wpp_pkg.sv =====
`default_nettype none
package wpp_pkg;

	localparam int MAX_WAYPOINTS = 64;
	localparam int AW            = $clog2(MAX_WAYPOINTS);
	localparam int PTR_W         = 7;
	localparam int CORDIC_STEPS  = 16;
	localparam int ATAN_N        = 24;
	localparam int CNT_W         = $clog2(ATAN_N);
	localparam int XW            = 52;
	localparam int ZW            = 31;
	localparam int IN_W          = 120;
	localparam int OUT_W         = 40;
	localparam int CFG_W         = 16;
	localparam int IDX_W         = 3;

	localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
	localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(26353589);
	localparam logic signed [ZW-1:0] TWO_PI_Q24  = ZW'(2 * 52707179);
	localparam logic signed [XW-1:0] K_Q30       = XW'(652032874);
	localparam logic signed [15:0]   STEER_LIMIT = 16'sd25736;

	// heading*PI/23040 = heading*HDG_A + (heading*HDG_B)/23040, 23040 = 512*45
	localparam logic [11:0] HDG_A     = 12'd2287;
	localparam logic [13:0] HDG_B     = 14'd14699;
	localparam logic [28:0] HDG_HALF  = 29'd11520;
	localparam logic [20:0] HDG_RECIP = 21'd1491309;
	localparam int          HDG_SH    = 26;

	localparam logic [IDX_W-1:0] REG_COUNT  = 3'd0;
	localparam logic [IDX_W-1:0] REG_WHEEL  = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN   = 3'd2;
	localparam logic [IDX_W-1:0] REG_RADIUS = 3'd3;
	localparam logic [IDX_W-1:0] REG_JSPEED = 3'd4;
	localparam logic [IDX_W-1:0] REG_NSPEED = 3'd5;

	typedef struct packed {
		logic             load_wr;
		logic             pose_lat;
		logic             rd;
		logic             cap;
		logic             fin;
		logic             vec_bear;
		logic             vec_steer;
		logic             cstep;
		logic             dstep;
		logic             alpha;
		logic             rinit;
		logic             sin;
		logic             mul;
		logic             steer;
		logic [CNT_W-1:0] cnt;
	} wpp_cmd_t;

	typedef struct packed {
		logic done_or_end;
		logic cap_end;
		logic out_free;
	} wpp_sts_t;

	function automatic logic signed [ZW-1:0] atan_q24(input logic [CNT_W-1:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:  v = ZW'(13176795);
			5'd1:  v = ZW'(7778716);
			5'd2:  v = ZW'(4110060);
			5'd3:  v = ZW'(2086331);
			5'd4:  v = ZW'(1047214);
			5'd5:  v = ZW'(524117);
			5'd6:  v = ZW'(262123);
			5'd7:  v = ZW'(131069);
			5'd8:  v = ZW'(65536);
			5'd9:  v = ZW'(32768);
			5'd10: v = ZW'(16384);
			5'd11: v = ZW'(8192);
			5'd12: v = ZW'(4096);
			5'd13: v = ZW'(2048);
			5'd14: v = ZW'(1024);
			5'd15: v = ZW'(512);
			5'd16: v = ZW'(256);
			5'd17: v = ZW'(128);
			5'd18: v = ZW'(64);
			5'd19: v = ZW'(32);
			5'd20: v = ZW'(16);
			5'd21: v = ZW'(8);
			5'd22: v = ZW'(4);
			5'd23: v = ZW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wpp_ctrl.sv =====
`default_nettype none
module wpp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              mode,
	input  wire wpp_pkg::wpp_sts_t sts,
	output logic                   s_tready,
	output wpp_pkg::wpp_cmd_t      cmd
);
	import wpp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_CAP   = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_SET   = 4'd4;
	localparam logic [3:0] S_VEC1  = 4'd5;
	localparam logic [3:0] S_ALPHA = 4'd6;
	localparam logic [3:0] S_RINIT = 4'd7;
	localparam logic [3:0] S_ROT   = 4'd8;
	localparam logic [3:0] S_SIN   = 4'd9;
	localparam logic [3:0] S_MUL   = 4'd10;
	localparam logic [3:0] S_VSET  = 4'd11;
	localparam logic [3:0] S_VEC2  = 4'd12;
	localparam logic [3:0] S_STEER = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.cnt = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_wr  = !mode;
					cmd.pose_lat = mode;
					if (mode)
						state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.rd  = 1'b1;
				state_d = sts.done_or_end ? S_FIN : S_CAP;
			end
			S_CAP: begin
				if (sts.out_free) begin
					cmd.cap = 1'b1;
					state_d = sts.cap_end ? S_IDLE : S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_SET;
			end
			S_SET: begin
				cmd.vec_bear = 1'b1;
				cnt_d        = '0;
				state_d      = S_VEC1;
			end
			S_VEC1: begin
				cmd.dstep = 1'b1;
				cmd.cstep = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
					state_d = S_ALPHA;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_ALPHA: begin
				cmd.alpha = 1'b1;
				state_d   = S_RINIT;
			end
			S_RINIT: begin
				cmd.rinit = 1'b1;
				cnt_d     = '0;
				state_d   = S_ROT;
			end
			S_ROT: begin
				cmd.cstep = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
					state_d = S_SIN;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_SIN: begin
				cmd.sin = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_VSET;
			end
			S_VSET: begin
				cmd.vec_steer = 1'b1;
				cnt_d         = '0;
				state_d       = S_VEC2;
			end
			S_VEC2: begin
				cmd.cstep = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
					state_d = S_STEER;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_STEER: begin
				cmd.steer = 1'b1;
				state_d   = S_IDLE;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wpp_dp.sv =====
`default_nettype none
module wpp_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [wpp_pkg::IN_W-1:0]   s_tdata,
	input  wire logic                       cfg_we,
	input  wire logic [wpp_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [wpp_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       m_tready,
	input  wire wpp_pkg::wpp_cmd_t          cmd,
	output wpp_pkg::wpp_sts_t               sts,
	output logic                            m_tvalid,
	output logic [wpp_pkg::OUT_W-1:0]       m_tdata
);
	import wpp_pkg::*;

	// config
	logic [6:0]  count_q;
	logic [11:0] wb_q;
	logic [15:0] gain_q;
	logic [11:0] rad_q;
	logic [13:0] jspd_q, nspd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd22;
			wb_q    <= 12'd251;
			gain_q  <= 16'd819;
			rad_q   <= 12'd768;
			jspd_q  <= 14'd1280;
			nspd_q  <= 14'd2176;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUNT:  count_q <= cfg_data[6:0];
				REG_WHEEL:  wb_q    <= cfg_data[11:0];
				REG_GAIN:   gain_q  <= cfg_data;
				REG_RADIUS: rad_q   <= cfg_data[11:0];
				REG_JSPEED: jspd_q  <= cfg_data[13:0];
				REG_NSPEED: nspd_q  <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	logic [PTR_W-1:0] count_eff;
	assign count_eff = (count_q > PTR_W'(MAX_WAYPOINTS)) ? PTR_W'(MAX_WAYPOINTS) : count_q;

	// waypoint table
	logic [39:0] mem [MAX_WAYPOINTS];
	logic [39:0] rd_q;
	logic [PTR_W-1:0] ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			mem[s_tdata[AW-1:0]] <= s_tdata[45:6];
		if (cmd.rd)
			rd_q <= mem[ptr_q[AW-1:0]];
	end

	// latched pose
	logic signed [19:0] px_q, py_q;
	logic signed [15:0] hdg_q;
	logic [13:0]        spd_q;
	logic               junc_q;

	always_ff @(posedge clk) begin
		if (cmd.pose_lat) begin
			px_q   <= s_tdata[65:46];
			py_q   <= s_tdata[85:66];
			hdg_q  <= s_tdata[101:86];
			spd_q  <= s_tdata[115:102];
			junc_q <= s_tdata[116];
		end
	end

	// capture square
	logic signed [21:0] tx, ty, pxe, pye, r;
	logic               in_box;
	logic [PTR_W-1:0]   ptr_new;

	assign tx      = 22'(signed'(rd_q[19:0]));
	assign ty      = 22'(signed'(rd_q[39:20]));
	assign pxe     = 22'(px_q);
	assign pye     = 22'(py_q);
	assign r       = $signed({10'd0, rad_q});
	assign in_box  = (pxe > tx - r) && (pxe < tx + r) && (pye > ty - r) && (pye < ty + r);
	assign ptr_new = ptr_q + PTR_W'(in_box);

	// CORDIC unit, vectoring or rotation
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic                 zero_q, rot_q, neg_q;
	logic signed [XW-1:0] vx, vy, sx, sy;
	logic signed [20:0]   dx, dy;
	logic signed [45:0]   num_q;
	logic [29:0]          den_q;
	logic                 up;

	assign dx = 21'(tx) - 21'(pxe);
	assign dy = 21'(ty) - 21'(pye);
	assign vx = cmd.vec_bear ? (XW'(dx) <<< 20) : $signed({4'd0, den_q, 18'd0});
	assign vy = cmd.vec_bear ? (XW'(dy) <<< 20) : XW'(num_q);
	assign sx = x_q >>> cmd.cnt;
	assign sy = y_q >>> cmd.cnt;
	assign up = rot_q ? (z_q >= 0) : (y_q < 0);

	// heading scaling, two stages beside the bearing pass
	logic [26:0]  hb_q, q_q;
	logic [28:0]  hp_q;
	logic [40:0]  hm;
	logic         hneg_q;
	logic [16:0]  hmag;

	assign hmag = hdg_q[15] ? 17'(-$signed({hdg_q[15], hdg_q})) : {1'b0, hdg_q};
	assign hm   = hp_q[28:9] * HDG_RECIP;

	// alpha and sine
	logic signed [ZW-1:0] alpha_q, hq, bear, a0, aw;
	logic signed [31:0]   s_q, yc;

	assign hq   = hneg_q ? -ZW'(q_q) : ZW'(q_q);
	assign bear = zero_q ? '0 : z_q;
	assign a0   = hq - bear;
	assign aw   = (a0 <= -PI_Q24) ? a0 + TWO_PI_Q24 :
	              (a0 >= PI_Q24)  ? a0 - TWO_PI_Q24 : a0;
	assign yc   = (y_q > (XW'(1) <<< 30))  ? 32'sd1073741824 :
	              (y_q < -(XW'(1) <<< 30)) ? -32'sd1073741824 : 32'(y_q);

	always_ff @(posedge clk) begin
		if (cmd.vec_bear || cmd.vec_steer) begin
			zero_q <= (vx == 0) && (vy == 0);
			rot_q  <= 1'b0;
			if (vx < 0) begin
				z_q <= (vy >= 0) ? PI_Q24 : -PI_Q24;
				x_q <= -vx;
				y_q <= -vy;
			end else begin
				z_q <= '0;
				x_q <= vx;
				y_q <= vy;
			end
		end else if (cmd.rinit) begin
			rot_q <= 1'b1;
			x_q   <= K_Q30;
			y_q   <= '0;
			if (alpha_q > HALF_PI_Q24) begin
				z_q   <= alpha_q - PI_Q24;
				neg_q <= 1'b1;
			end else if (alpha_q < -HALF_PI_Q24) begin
				z_q   <= alpha_q + PI_Q24;
				neg_q <= 1'b1;
			end else begin
				z_q   <= alpha_q;
				neg_q <= 1'b0;
			end
		end else if (cmd.cstep) begin
			if (up) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - atan_q24(cmd.cnt);
			end else begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + atan_q24(cmd.cnt);
			end
		end
		if (cmd.vec_bear) begin
			hb_q   <= 27'(hmag) * 27'(HDG_A);
			hp_q   <= 29'(hmag) * 29'(HDG_B) + HDG_HALF;
			hneg_q <= hdg_q[15];
		end else if (cmd.dstep) begin
			q_q <= hb_q + 27'(hm >> HDG_SH);
		end
		if (cmd.alpha)
			alpha_q <= aw;
		if (cmd.sin)
			s_q <= neg_q ? -yc : yc;
		if (cmd.mul) begin
			num_q <= 46'(s_q) * 46'($signed({1'b0, wb_q, 1'b0}));
			den_q <= gain_q * spd_q;
		end
	end

	// steering result and output register
	logic signed [15:0]   last_q;
	logic                 done_q;
	logic signed [ZW-1:0] dsum, dsh;
	logic signed [15:0]   steer_c;

	assign dsum    = bear + ZW'(512);
	assign dsh     = dsum >>> 10;
	assign steer_c = (dsh > ZW'(STEER_LIMIT))  ? STEER_LIMIT :
	                 (dsh < -ZW'(STEER_LIMIT)) ? -STEER_LIMIT : 16'(dsh);

	logic signed [15:0] o_steer_q;
	logic [13:0]        o_speed_q;
	logic               o_drv_q;
	logic [PTR_W-1:0]   o_wp_q;
	logic               out_v_q;

	assign sts.out_free    = !out_v_q || m_tready;
	assign sts.done_or_end = done_q || (ptr_q >= count_eff);
	assign sts.cap_end     = (ptr_new >= count_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			last_q  <= '0;
			done_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				ptr_q <= ptr_new;
				if (ptr_new >= count_eff) begin
					done_q <= 1'b1;
					last_q <= '0;
				end
			end
			if (cmd.fin) begin
				done_q <= 1'b1;
				last_q <= '0;
			end
			if (cmd.steer)
				last_q <= steer_c;
			if (cmd.cap || cmd.fin)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			o_wp_q <= ptr_new;
			if (ptr_new >= count_eff) begin
				o_steer_q <= '0;
				o_speed_q <= '0;
				o_drv_q   <= 1'b0;
			end else begin
				o_steer_q <= last_q;
				o_speed_q <= junc_q ? jspd_q : nspd_q;
				o_drv_q   <= 1'b1;
			end
		end else if (cmd.fin) begin
			o_wp_q    <= ptr_q;
			o_steer_q <= '0;
			o_speed_q <= '0;
			o_drv_q   <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, o_wp_q, o_drv_q, o_speed_q, o_steer_q};

endmodule
`default_nettype wire

// ===== rtl/core/waypoint_pure_pursuit_steering_unit.sv =====
`default_nettype none
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser mode, s_tdata pose or waypoint
// m_*      out  m_tvalid/m_tready  m_tdata steering result
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// A load item is written while idle, and the unit stays ready. A pose item
// runs the shared CORDIC unit (bearing, sine, steering atan2 at 16 steps each);
// the heading scaling, a two-stage constant multiply, runs beside the bearing
// pass. A finished route or a pose that ends the route skips the CORDIC.
// Reset clears pointer, held steering and route state, presets config; the table
// holds garbage until loaded. A stalled m_tready holds a pose at its transfer.
module waypoint_pure_pursuit_steering_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// load_slot, point_x, point_y, pos_x, pos_y, heading, speed, at_junction
	input  wire logic [wpp_pkg::IN_W-1:0]   s_tdata,
	// mode
	input  wire logic [0:0]                 s_tuser,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// steer_angle, target_speed, driving, current_waypoint
	output logic [wpp_pkg::OUT_W-1:0]       m_tdata,
	input  wire logic                       cfg_we,
	input  wire logic [wpp_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [wpp_pkg::CFG_W-1:0]  cfg_data
);
	import wpp_pkg::*;

	wpp_cmd_t cmd;
	wpp_sts_t sts;

	wpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser[0]),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	wpp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

// ===== rtl/core/wpp_checker.sv =====
`default_nettype none
module wpp_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [wpp_pkg::OUT_W-1:0] m_tdata
);
	import wpp_pkg::*;

	logic fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fin_q <= 1'b0;
		else if (m_tvalid && m_tready && !m_tdata[30])
			fin_q <= 1'b1;
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[30] |-> m_tdata[29:0] == 30'd0)
		else $error("finished result carries steering or speed");

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && fin_q |-> !m_tdata[30])
		else $error("driving again after route finished");

endmodule

bind waypoint_pure_pursuit_steering_unit wpp_checker u_wpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
